/* rtl/assert_macros.svh */
// Assertion helpers. Each macro expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define B64E_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define B64E_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* rtl/b64e_pkg.sv */
package b64e_pkg;

    localparam int GROUP_W = 24;
    localparam logic [7:0] PAD_CHAR = 8'h40;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last_char;
    } out_item_t;

    // one group of three byte slots, left aligned, with pad count
    typedef struct packed {
        logic [GROUP_W-1:0] word;
        logic [1:0]         npad;
        logic               last;
    } grp_t;

    function automatic logic [7:0] b64e_sym(input logic [5:0] v);
        logic [7:0] r;
        if (v < 6'd10)
            r = 8'h30 + {2'b00, v};
        else if (v < 6'd36)
            r = 8'h41 + {2'b00, v} - 8'd10;
        else if (v < 6'd62)
            r = 8'h61 + {2'b00, v} - 8'd36;
        else if (v == 6'd62)
            r = 8'h5f;
        else
            r = 8'h7e;
        return r;
    endfunction

endpackage

/* rtl/b64e_stream_if.sv */
interface b64e_stream_if #(
    parameter type payload_t = logic [7:0]
) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* rtl/base64_custom_alphabet_encoder.sv */
// Streaming base64-style encoder, alphabet 0-9 A-Z a-z _ ~, pad '@'.
// raw: one byte per item (data_byte, last_byte marks the final byte).
// enc: one character per item (out_char, last_char on the final character).
// Every third byte, or a byte with last_byte set, closes a group that yields
// four characters; short groups are padded with '@'.
// The front holds the partial group and accepts one byte per cycle while the
// group queue (QUEUE_DEPTH entries) has room. The back serializes one
// character per cycle, while enc accepts, from the queue head into an output register.
// The first character of a group passes the queue, the current-group register
// and the output register after the byte closing the group is taken. Throughput
// is set by the one-character-per-cycle output port, four per three-byte group.
// When enc stalls, the output item holds, the queue fills and raw.ready drops
// once QUEUE_DEPTH groups are waiting; bytes that do not close a group still
// need a free queue entry to be taken.
// Reset clears the partial group, the queue and the output valid.
`include "assert_macros.svh"

module base64_custom_alphabet_encoder #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic          clk,
    input  logic          rst_n,
    b64e_stream_if.sink   raw,
    b64e_stream_if.source enc
);
    import b64e_pkg::*;

    logic grp_valid;
    grp_t grp;
    logic q_ready;
    logic q_valid;
    grp_t q_data;
    logic q_pop;

    b64e_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .raw       (raw),
        .q_ready   (q_ready),
        .grp_valid (grp_valid),
        .grp       (grp)
    );

    b64e_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (grp_valid),
        .push_data  (grp),
        .push_ready (q_ready),
        .pop_valid  (q_valid),
        .pop_data   (q_data),
        .pop        (q_pop)
    );

    b64e_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_data  (q_data),
        .q_pop   (q_pop),
        .enc     (enc)
    );

    `B64E_ASSERT_IMP(a_flush_emits, raw.valid && raw.ready && raw.data.last_byte, grp_valid)
    `B64E_ASSERT_IMP(a_short_grp_last, grp_valid && grp.npad != 2'd0, grp.last)
    `B64E_ASSERT_IMP(a_no_push_full, grp_valid, q_ready)
    `B64E_ASSERT_NXT(a_pop_then_out, q_pop, ##1 enc.valid)

endmodule

/* rtl/b64e_queue.sv */
module b64e_queue #(
    parameter int DEPTH = 2
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  b64e_pkg::grp_t push_data,
    output logic          push_ready,
    output logic          pop_valid,
    output b64e_pkg::grp_t pop_data,
    input  logic          pop
);
    import b64e_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    grp_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (!do_push && do_pop)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_data;
    end

endmodule

/* rtl/b64e_front.sv */
module b64e_front (
    input  logic           clk,
    input  logic           rst_n,
    b64e_stream_if.sink    raw,
    input  logic           q_ready,
    output logic           grp_valid,
    output b64e_pkg::grp_t grp
);
    import b64e_pkg::*;

    localparam logic [1:0] FILL_NONE = 2'd0;
    localparam logic [1:0] FILL_ONE  = 2'd1;
    localparam logic [1:0] FILL_TWO  = 2'd2;

    logic [15:0] pend_reg, pend_next;
    logic [1:0]  fill_reg, fill_next;
    logic        accept;
    logic [7:0]  b;

    assign raw.ready = q_ready;
    assign accept    = raw.valid && raw.ready;
    assign b         = raw.data.data_byte;

    always_comb
    begin
        pend_next = pend_reg;
        fill_next = fill_reg;
        grp_valid = 1'b0;
        grp.word  = {pend_reg, b};
        grp.npad  = 2'd0;
        grp.last  = raw.data.last_byte;
        unique case (fill_reg)
            FILL_TWO:
            begin
                grp.npad = 2'd0;
                grp.word = {pend_reg, b};
            end
            FILL_ONE:
            begin
                grp.npad = 2'd1;
                grp.word = {pend_reg[7:0], b, 8'h00};
            end
            default:
            begin
                grp.npad = 2'd2;
                grp.word = {b, 16'h0000};
            end
        endcase
        if (accept)
        begin
            if (fill_reg == FILL_TWO || raw.data.last_byte)
            begin
                grp_valid = 1'b1;
                pend_next = '0;
                fill_next = FILL_NONE;
            end
            else
            begin
                pend_next = {pend_reg[7:0], b};
                fill_next = (fill_reg == FILL_ONE) ? FILL_TWO : FILL_ONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
            fill_reg <= FILL_NONE;
        end
        else
        begin
            pend_reg <= pend_next;
            fill_reg <= fill_next;
        end
    end

endmodule

/* rtl/b64e_back.sv */
module b64e_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    input  b64e_pkg::grp_t q_data,
    output logic           q_pop,
    b64e_stream_if.source  enc
);
    import b64e_pkg::*;

    grp_t       cur_reg, cur_next;
    logic [1:0] idx_reg, idx_next;
    logic       busy_reg, busy_next;
    logic       ovalid_reg, ovalid_next;
    logic [7:0] char_reg, char_next;
    logic       lastc_reg, lastc_next;
    logic       out_free;
    logic [5:0] sel;
    logic       is_pad;

    assign out_free = !ovalid_reg || enc.ready;
    assign q_pop    = q_valid && (!busy_reg || (out_free && idx_reg == 2'd3));
    assign is_pad   = ({1'b0, idx_reg} + {1'b0, cur_reg.npad}) >= 3'd4;

    always_comb
    begin
        unique case (idx_reg)
            2'd0:    sel = cur_reg.word[23:18];
            2'd1:    sel = cur_reg.word[17:12];
            2'd2:    sel = cur_reg.word[11:6];
            default: sel = cur_reg.word[5:0];
        endcase
    end

    always_comb
    begin
        cur_next    = cur_reg;
        idx_next    = idx_reg;
        busy_next   = busy_reg;
        ovalid_next = ovalid_reg;
        char_next   = char_reg;
        lastc_next  = lastc_reg;
        if (busy_reg && out_free)
        begin
            ovalid_next = 1'b1;
            char_next   = is_pad ? PAD_CHAR : b64e_sym(sel);
            lastc_next  = cur_reg.last && (idx_reg == 2'd3);
            idx_next    = idx_reg + 2'd1;
            if (idx_reg == 2'd3)
                busy_next = 1'b0;
        end
        else if (out_free)
        begin
            ovalid_next = 1'b0;
        end
        if (q_pop)
        begin
            cur_next  = q_data;
            idx_next  = 2'd0;
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg    <= '0;
            busy_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            idx_reg    <= idx_next;
            busy_reg   <= busy_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg   <= cur_next;
        char_reg  <= char_next;
        lastc_reg <= lastc_next;
    end

    assign enc.valid          = ovalid_reg;
    assign enc.data.out_char  = char_reg;
    assign enc.data.last_char = lastc_reg;

endmodule

/* test/tb_base64_custom_alphabet_encoder.sv */
`timescale 1ns / 100ps

module tb_base64_custom_alphabet_encoder;

    import b64e_pkg::*;

    localparam string SYMBOLS =
        "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz_~";
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES = 150;
    localparam int DRAIN_CYCLES = 12;

    logic clk;
    logic rst_n;

    b64e_stream_if #(.payload_t(in_item_t)) raw_if ();
    b64e_stream_if #(.payload_t(out_item_t)) enc_if ();

    base64_custom_alphabet_encoder dut (
        .clk(clk),
        .rst_n(rst_n),
        .raw(raw_if),
        .enc(enc_if)
    );

    in_item_t   byte_q[$];
    out_item_t  char_q[$];
    out_item_t  want_char;
    logic [15:0] pend_bytes;
    logic [1:0]  group_fill;
    int send_idle_pct;
    int recv_stall_pct;
    int errors;
    int stall_count;
    int hold_left;
    logic hold_req;
    logic hold_done;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic out_item_t make_char(input logic [7:0] ch, input logic last);
        out_item_t c;
        c.out_char = ch;
        c.last_char = last;
        return c;
    endfunction

    function automatic logic [7:0] symbol_of(input logic [5:0] idx);
        return SYMBOLS[idx];
    endfunction

    // expected characters caused by one accepted byte
    task automatic encode_byte(input in_item_t it);
        logic [23:0] v;
        if (group_fill == 2'd2)
        begin
            v = {pend_bytes, it.data_byte};
            char_q.push_back(make_char(symbol_of(v[23:18]), 1'b0));
            char_q.push_back(make_char(symbol_of(v[17:12]), 1'b0));
            char_q.push_back(make_char(symbol_of(v[11:6]), 1'b0));
            char_q.push_back(make_char(symbol_of(v[5:0]), it.last_byte));
            pend_bytes = '0;
            group_fill = '0;
        end
        else
        begin
            pend_bytes = {pend_bytes[7:0], it.data_byte};
            group_fill = group_fill + 2'd1;
            if (it.last_byte)
            begin
                if (group_fill == 2'd2)
                begin
                    v = {6'd0, pend_bytes, 2'b00};
                    char_q.push_back(make_char(symbol_of(v[17:12]), 1'b0));
                    char_q.push_back(make_char(symbol_of(v[11:6]), 1'b0));
                    char_q.push_back(make_char(symbol_of(v[5:0]), 1'b0));
                    char_q.push_back(make_char(PAD_CHAR, 1'b1));
                end
                else
                begin
                    v = {12'd0, pend_bytes[7:0], 4'b0000};
                    char_q.push_back(make_char(symbol_of(v[11:6]), 1'b0));
                    char_q.push_back(make_char(symbol_of(v[5:0]), 1'b0));
                    char_q.push_back(make_char(PAD_CHAR, 1'b0));
                    char_q.push_back(make_char(PAD_CHAR, 1'b1));
                end
                pend_bytes = '0;
                group_fill = '0;
            end
        end
    endtask

    task automatic push_byte(input logic [7:0] b, input logic last);
        in_item_t it;
        it.data_byte = b;
        it.last_byte = last;
        byte_q.push_back(it);
    endtask

    task automatic queue_message(input int len);
        for (int i = 0; i < len; i++)
            push_byte(8'($urandom), i == len - 1);
    endtask

    function automatic int message_len();
        if ($urandom_range(9) == 0)
            return $urandom_range(10, 24);
        return $urandom_range(1, 8);
    endfunction

    task automatic run_messages(input int n_bytes);
        int sent;
        int len;
        sent = 0;
        while (sent < n_bytes)
        begin
            while (byte_q.size() > 8)
                @(negedge clk);
            len = message_len();
            queue_message(len);
            sent += len;
        end
    endtask

    task automatic wait_drain();
        while (byte_q.size() != 0 || raw_if.valid || char_q.size() != 0)
            @(negedge clk);
    endtask

    // byte source
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_if.valid <= 1'b0;
            raw_if.data <= '0;
        end
        else if (!raw_if.valid || raw_if.ready)
        begin
            if (byte_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                raw_if.valid <= 1'b1;
                raw_if.data <= byte_q.pop_front();
            end
            else
                raw_if.valid <= 1'b0;
        end
    end

    // character sink
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            enc_if.ready <= 1'b0;
        else
            enc_if.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end

    // long receiver hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_req && !hold_done)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // check characters, then predict from the byte taken at this edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (enc_if.valid && enc_if.ready)
            begin
                if (char_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected char: expected none, actual %h last %b",
                             $time, enc_if.data.out_char, enc_if.data.last_char);
                end
                else
                begin
                    want_char = char_q.pop_front();
                    if (enc_if.data.out_char !== want_char.out_char)
                    begin
                        errors++;
                        $display("%0t: out_char mismatch: expected %h, actual %h",
                                 $time, want_char.out_char, enc_if.data.out_char);
                    end
                    if (enc_if.data.last_char !== want_char.last_char)
                    begin
                        errors++;
                        $display("%0t: last_char mismatch: expected %b, actual %b",
                                 $time, want_char.last_char, enc_if.data.last_char);
                    end
                end
            end
            if (raw_if.valid && raw_if.ready)
                encode_byte(raw_if.data);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((raw_if.valid && raw_if.ready) || (enc_if.valid && enc_if.ready))
                stall_count <= 0;
            else if (stall_count >= WATCHDOG_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
            else
                stall_count <= stall_count + 1;
        end
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        raw_if.valid = 1'b0;
        raw_if.data = '0;
        enc_if.ready = 1'b0;
        pend_bytes = '0;
        group_fill = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        errors = 0;
        stall_count = 0;
        hold_req = 1'b0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // single bytes at both extremes
        push_byte(8'h00, 1'b1);
        push_byte(8'hFF, 1'b1);
        // two-byte partial group
        push_byte(8'hFF, 1'b0);
        push_byte(8'hFF, 1'b1);
        // group completed by the last byte
        push_byte(8'h00, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h00, 1'b1);
        // underscore and tilde groups, then a two-byte tail
        push_byte(8'hFB, 1'b0);
        push_byte(8'hEF, 1'b0);
        push_byte(8'hBE, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h12, 1'b0);
        push_byte(8'h34, 1'b1);
        // group then a one-byte tail
        push_byte(8'hAB, 1'b0);
        push_byte(8'hCD, 1'b0);
        push_byte(8'hEF, 1'b0);
        push_byte(8'h01, 1'b1);
        wait_drain();

        // no idling, receiver holds off while bytes keep coming
        while (byte_q.size() < 30)
            queue_message(message_len());
        hold_req = 1'b1;
        run_messages(45);

        send_idle_pct = 47;
        recv_stall_pct = 0;
        run_messages(75);

        send_idle_pct = 0;
        recv_stall_pct = 47;
        run_messages(75);

        send_idle_pct = 37;
        recv_stall_pct = 37;
        run_messages(75);

        wait_drain();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
